// ----- src/cicma_pkg.sv -----
// ----------------------------------------------------------------------------
// cicma_pkg
// Types and codes shared by the cloud-in-cell mass assignment core.
// ----------------------------------------------------------------------------
package cicma_pkg;

  localparam int DIMENSIONS  = 3;
  localparam int NUM_CORNERS = 1 << DIMENSIONS;

  localparam int CELL_W     = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};
  localparam logic [16:0]       ONE_Q16  = 17'h10000;

  localparam logic [1:0] ACT_DEPOSIT = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_WRITE   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MESH_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESH_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MESH_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_EN   = 3'd6;

  typedef struct packed {
    logic [1:0]        action;
    logic [31:0]       pos_x;
    logic [31:0]       pos_y;
    logic [31:0]       pos_z;
    logic [23:0]       particle_weight;
    logic [4:0]        cell_x;
    logic [4:0]        cell_y;
    logic [4:0]        cell_z;
    logic [CELL_W-1:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CELL_W-1:0] cell_value;
  } out_word_t;

endpackage

// ----- src/cicma_ram.sv -----
// ----------------------------------------------------------------------------
// cicma_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cicma_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/cic_mass_assignment_3d_core.sv -----
// ----------------------------------------------------------------------------
// cic_mass_assignment_3d_core
// Cloud-in-cell deposit of weighted particles onto a periodic 3D mesh of
// saturating 40-bit cells, with single-cell read and write words.
// ----------------------------------------------------------------------------
// After reset the core zeroes the whole mesh memory, one cell per cycle
// (MAX_MESH_X*MAX_MESH_Y*MAX_MESH_Z cells, 32768 by default); no input word
// is taken during that pass, configuration writes are. Taking a deposit word
// registers its scaled position; the check state splits and range-checks it;
// eight corner updates are issued one per cycle; a three-stage multiply and
// read-modify-write pipeline drains, all on the single write port of the
// mesh memory. A read word uses the command and read-data states, a
// write word the command state, an out-of-mesh deposit the check state. A
// finished result waits in the output register while the next word is taken.
module cic_mass_assignment_3d_core #(
  parameter int MAX_MESH_X = 32,
  parameter int MAX_MESH_Y = 32,
  parameter int MAX_MESH_Z = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [cicma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cicma_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  cicma_pkg::in_word_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output cicma_pkg::out_word_t                 out_data
);

  localparam int XW    = $clog2(MAX_MESH_X);
  localparam int YW    = $clog2(MAX_MESH_Y);
  localparam int ZW    = $clog2(MAX_MESH_Z);
  localparam int DEPTH = MAX_MESH_X * MAX_MESH_Y * MAX_MESH_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = cicma_pkg::CELL_W;
  localparam int KW    = cicma_pkg::DIMENSIONS;

  localparam logic [AW-1:0] STRIDE_X  = AW'(MAX_MESH_Y * MAX_MESH_Z);
  localparam logic [AW-1:0] STRIDE_Y  = AW'(MAX_MESH_Z);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [KW-1:0] LAST_CORNER = KW'(cicma_pkg::NUM_CORNERS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CMD   = 3'd2;
  localparam logic [2:0] S_RDATA = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_RUN   = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  function automatic logic [8:0] eff_size(input logic [5:0] r, input logic [8:0] mx);
    if (r == 6'd0) begin
      return 9'd1;
    end
    if (9'(r) > mx) begin
      return mx;
    end
    return 9'(r);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y,
                                              input logic [ZW-1:0] z);
    return AW'(x) * STRIDE_X + AW'(y) * STRIDE_Y + AW'(z);
  endfunction

  // configuration
  logic [5:0]  mesh_size_x_r, mesh_size_y_r, mesh_size_z_r;
  logic [31:0] scale_x_r, scale_y_r, scale_z_r;
  logic        weight_en_r;
  logic [8:0]  size_x, size_y, size_z;

  // control
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r;
  logic          in_accept;

  // item
  logic [1:0]    act_r;
  logic [4:0]    cx_r, cy_r, cz_r;
  logic [CW-1:0] wval_r;
  logic [23:0]   w_r;
  logic [63:0]   prod_x, prod_y, prod_z;
  logic [39:0]   u_x_r, u_y_r, u_z_r;
  logic          pos_in, cmd_in;
  logic [AW-1:0] cmd_addr;

  // deposit
  logic [XW-1:0] idx_x_r, hi_x_r;
  logic [YW-1:0] idx_y_r, hi_y_r;
  logic [ZW-1:0] idx_z_r, hi_z_r;
  logic [8:0]    nxt_x, nxt_y, nxt_z;
  logic [15:0]   frac_x_r, frac_y_r, frac_z_r;
  logic [KW-1:0] corner_r;
  logic          sat_r;
  logic [16:0]   fac_x, fac_y, fac_z;
  logic [AW-1:0] corner_addr;

  // corner pipeline
  logic          a_v_r, b_v_r, c_v_r;
  logic [AW-1:0] a_addr_r, b_addr_r, c_addr_r;
  logic [33:0]   a_p01_r;
  logic [16:0]   a_fac_z_r;
  logic [34:0]   ratio_full;
  logic [16:0]   b_ratio_r;
  logic [40:0]   contrib_full;
  logic [23:0]   c_contrib_r;
  logic [40:0]   sum;
  logic          sum_sat;
  logic [CW-1:0] sum_wdata;

  // memory and forwarding
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, raddr_r;
  logic [CW-1:0] ram_wdata, ram_rdata, rdata_fw;
  logic          lw_valid_r;
  logic [AW-1:0] lw_addr_r;
  logic [CW-1:0] lw_data_r;

  // result
  logic [1:0]           res_status_r;
  logic [CW-1:0]        res_value_r;
  logic                 out_valid_r;
  cicma_pkg::out_word_t out_data_r;

  assign size_x = eff_size(mesh_size_x_r, 9'(MAX_MESH_X));
  assign size_y = eff_size(mesh_size_y_r, 9'(MAX_MESH_Y));
  assign size_z = eff_size(mesh_size_z_r, 9'(MAX_MESH_Z));

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign prod_x = 64'(in_data.pos_x) * 64'(scale_x_r);
  assign prod_y = 64'(in_data.pos_y) * 64'(scale_y_r);
  assign prod_z = 64'(in_data.pos_z) * 64'(scale_z_r);

  assign pos_in = (u_x_r[39:16] < 24'(size_x)) && (u_y_r[39:16] < 24'(size_y)) &&
                  (u_z_r[39:16] < 24'(size_z));

  assign nxt_x = 9'(XW'(u_x_r[39:16])) + 9'd1;
  assign nxt_y = 9'(YW'(u_y_r[39:16])) + 9'd1;
  assign nxt_z = 9'(ZW'(u_z_r[39:16])) + 9'd1;

  assign cmd_in   = (9'(cx_r) < size_x) && (9'(cy_r) < size_y) && (9'(cz_r) < size_z);
  assign cmd_addr = cell_addr(XW'(cx_r), YW'(cy_r), ZW'(cz_r));

  assign fac_x = corner_r[0] ? {1'b0, frac_x_r} : cicma_pkg::ONE_Q16 - {1'b0, frac_x_r};
  assign fac_y = corner_r[1] ? {1'b0, frac_y_r} : cicma_pkg::ONE_Q16 - {1'b0, frac_y_r};
  assign fac_z = corner_r[2] ? {1'b0, frac_z_r} : cicma_pkg::ONE_Q16 - {1'b0, frac_z_r};
  assign corner_addr = cell_addr(corner_r[0] ? hi_x_r : idx_x_r,
                                 corner_r[1] ? hi_y_r : idx_y_r,
                                 corner_r[2] ? hi_z_r : idx_z_r);

  assign ratio_full   = 35'(a_p01_r[33:16]) * 35'(a_fac_z_r);
  assign contrib_full = 41'(w_r) * 41'(b_ratio_r);

  assign rdata_fw  = (lw_valid_r && lw_addr_r == raddr_r) ? lw_data_r : ram_rdata;
  assign sum       = 41'(rdata_fw) + 41'(c_contrib_r);
  assign sum_sat   = sum[40];
  assign sum_wdata = sum_sat ? cicma_pkg::CELL_MAX : sum[39:0];

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = c_addr_r;
    ram_wdata = sum_wdata;
    ram_raddr = b_addr_r;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_data.action == cicma_pkg::ACT_DEPOSIT) ? S_CHECK : S_CMD;
        end
      end
      S_CMD: begin
        ram_raddr = cmd_addr;
        state_nxt = S_DONE;
        case (act_r)
          cicma_pkg::ACT_READ: begin
            if (cmd_in) begin
              state_nxt = S_RDATA;
            end
          end
          cicma_pkg::ACT_WRITE: begin
            if (cmd_in) begin
              ram_we    = 1'b1;
              ram_waddr = cmd_addr;
              ram_wdata = wval_r;
            end
          end
          default: ;
        endcase
      end
      S_RDATA: state_nxt = S_DONE;
      S_CHECK: state_nxt = pos_in ? S_RUN : S_DONE;
      S_RUN: begin
        if (corner_r == LAST_CORNER) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!a_v_r && !b_v_r && !c_v_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (c_v_r) begin
      ram_we    = 1'b1;
      ram_waddr = c_addr_r;
      ram_wdata = sum_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      a_v_r         <= 1'b0;
      b_v_r         <= 1'b0;
      c_v_r         <= 1'b0;
      lw_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      mesh_size_x_r <= 6'd32;
      mesh_size_y_r <= 6'd32;
      mesh_size_z_r <= 6'd32;
      scale_x_r     <= 32'h0100_0000;
      scale_y_r     <= 32'h0100_0000;
      scale_z_r     <= 32'h0100_0000;
      weight_en_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      a_v_r      <= (state_r == S_RUN);
      b_v_r      <= a_v_r;
      c_v_r      <= b_v_r;
      lw_valid_r <= ram_we;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_DONE && state_nxt == S_IDLE) begin
        out_valid_r <= 1'b1;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          cicma_pkg::CFG_MESH_SIZE_X: mesh_size_x_r <= cfg_wdata[5:0];
          cicma_pkg::CFG_MESH_SIZE_Y: mesh_size_y_r <= cfg_wdata[5:0];
          cicma_pkg::CFG_MESH_SIZE_Z: mesh_size_z_r <= cfg_wdata[5:0];
          cicma_pkg::CFG_SCALE_X:     scale_x_r     <= cfg_wdata;
          cicma_pkg::CFG_SCALE_Y:     scale_y_r     <= cfg_wdata;
          cicma_pkg::CFG_SCALE_Z:     scale_z_r     <= cfg_wdata;
          cicma_pkg::CFG_WEIGHT_EN:   weight_en_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lw_addr_r   <= ram_waddr;
    lw_data_r   <= ram_wdata;
    raddr_r     <= ram_raddr;
    a_addr_r    <= corner_addr;
    a_fac_z_r   <= fac_z;
    a_p01_r     <= 34'(fac_x) * 34'(fac_y);
    b_addr_r    <= a_addr_r;
    b_ratio_r   <= ratio_full[32:16];
    c_addr_r    <= b_addr_r;
    c_contrib_r <= contrib_full[39:16];
    if (c_v_r && sum_sat) begin
      sat_r <= 1'b1;
    end
    if (in_accept) begin
      act_r  <= in_data.action;
      cx_r   <= in_data.cell_x;
      cy_r   <= in_data.cell_y;
      cz_r   <= in_data.cell_z;
      wval_r <= in_data.write_value;
      w_r    <= weight_en_r ? in_data.particle_weight : 24'(cicma_pkg::ONE_Q16);
      u_x_r  <= prod_x[63:24];
      u_y_r  <= prod_y[63:24];
      u_z_r  <= prod_z[63:24];
    end
    case (state_r)
      S_CMD: begin
        res_value_r  <= '0;
        res_status_r <= cicma_pkg::ST_OK;
        if ((act_r inside {cicma_pkg::ACT_READ, cicma_pkg::ACT_WRITE}) && !cmd_in) begin
          res_status_r <= cicma_pkg::ST_RANGE;
        end
      end
      S_RDATA: res_value_r <= rdata_fw;
      S_CHECK: begin
        idx_x_r      <= XW'(u_x_r[39:16]);
        idx_y_r      <= YW'(u_y_r[39:16]);
        idx_z_r      <= ZW'(u_z_r[39:16]);
        hi_x_r       <= (nxt_x >= size_x) ? '0 : XW'(nxt_x);
        hi_y_r       <= (nxt_y >= size_y) ? '0 : YW'(nxt_y);
        hi_z_r       <= (nxt_z >= size_z) ? '0 : ZW'(nxt_z);
        frac_x_r     <= u_x_r[15:0];
        frac_y_r     <= u_y_r[15:0];
        frac_z_r     <= u_z_r[15:0];
        corner_r     <= '0;
        sat_r        <= 1'b0;
        res_value_r  <= '0;
        res_status_r <= pos_in ? cicma_pkg::ST_OK : cicma_pkg::ST_RANGE;
      end
      S_RUN: corner_r <= corner_r + KW'(1);
      S_DRAIN: begin
        if (state_nxt == S_DONE) begin
          res_status_r <= sat_r ? cicma_pkg::ST_SAT : cicma_pkg::ST_OK;
        end
      end
      S_DONE: begin
        if (state_nxt == S_IDLE) begin
          out_data_r.status     <= res_status_r;
          out_data_r.cell_value <= res_value_r;
        end
      end
      default: ;
    endcase
  end

  cicma_ram #(
    .WIDTH(CW),
    .DEPTH(DEPTH)
  ) u_mesh_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`ifndef SYNTHESIS
  a_pipe_in_deposit: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r || b_v_r || c_v_r) |-> (state_r == S_RUN || state_r == S_DRAIN))
    else $error("corner pipeline active outside a deposit");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (!a_v_r && !b_v_r && !c_v_r))
    else $error("result issued before last corner written");

  a_cmd_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_CMD) |-> (act_r == cicma_pkg::ACT_WRITE && cmd_in))
    else $error("mesh written by a word that is not an in-mesh write");

  a_clear_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && clr_r != LAST_ADDR) |=> (state_r == S_CLEAR))
    else $error("clearing pass left early");
`endif

endmodule

// ----- test/mesh_deposit_checker.sv -----
// ----------------------------------------------------------------------------
// mesh_deposit_checker
// Watches the configuration port and both word channels of the cloud-in-cell
// core, keeps a shadow mesh and register set, predicts the result of every
// accepted input word and compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module mesh_deposit_checker
  import cicma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_word_t             out_data,
  output int                    mismatches,
  output int                    pending
);

  localparam int MESH_X = 32;
  localparam int MESH_Y = 32;
  localparam int MESH_Z = 32;
  localparam int MESH_CELLS = MESH_X * MESH_Y * MESH_Z;

  localparam logic [5:0]  RESET_SIZE  = 6'd32;
  localparam logic [31:0] RESET_SCALE = 32'h0100_0000;

  logic [CELL_W-1:0] mesh_shadow [MESH_CELLS];
  logic [5:0]        size_reg    [DIMENSIONS];
  logic [31:0]       scale_reg   [DIMENSIONS];
  logic              weight_en_reg;
  out_word_t         predicted_results [$];

  function automatic logic [63:0] clip_size(input logic [5:0] r, input int lim);
    if (r == 0) return 64'd1;
    if (r > lim) return lim;
    return {58'd0, r};
  endfunction

  function automatic out_word_t mesh_step(input in_word_t w);
    logic [63:0] extent [DIMENSIONS];
    logic [63:0] pos    [DIMENSIONS];
    logic [63:0] idx    [DIMENSIONS];
    logic [63:0] frac   [DIMENSIONS];
    logic [63:0] at     [DIMENSIONS];
    logic [63:0] fac    [DIMENSIONS];
    logic [63:0] u, ratio, wgt, sum, addr;
    logic        in_mesh, sat;
    int          c, d;
    out_word_t   r;
    r = '0;
    extent[0] = clip_size(size_reg[0], MESH_X);
    extent[1] = clip_size(size_reg[1], MESH_Y);
    extent[2] = clip_size(size_reg[2], MESH_Z);
    pos[0] = {32'd0, w.pos_x};
    pos[1] = {32'd0, w.pos_y};
    pos[2] = {32'd0, w.pos_z};
    case (w.action)
      ACT_DEPOSIT: begin
        in_mesh = 1'b1;
        for (d = 0; d < DIMENSIONS; d++) begin
          u = (pos[d] * {32'd0, scale_reg[d]}) >> 24;
          idx[d] = u >> 16;
          frac[d] = u & 64'hFFFF;
          if (idx[d] >= extent[d]) in_mesh = 1'b0;
        end
        if (!in_mesh) begin
          r.status = ST_RANGE;
        end else begin
          wgt = weight_en_reg ? {40'd0, w.particle_weight} : {47'd0, ONE_Q16};
          sat = 1'b0;
          for (c = 0; c < NUM_CORNERS; c++) begin
            for (d = 0; d < DIMENSIONS; d++) begin
              if (((c >> d) & 1) != 0) begin
                at[d] = idx[d] + 1;
                if (at[d] >= extent[d]) at[d] = 0;
                fac[d] = frac[d];
              end else begin
                at[d] = idx[d];
                fac[d] = {47'd0, ONE_Q16} - frac[d];
              end
            end
            ratio = (((fac[0] * fac[1]) >> 16) * fac[2]) >> 16;
            addr = (at[0] * MESH_Y + at[1]) * MESH_Z + at[2];
            sum = {24'd0, mesh_shadow[addr]} + ((wgt * ratio) >> 16);
            if (sum > {24'd0, CELL_MAX}) begin
              mesh_shadow[addr] = CELL_MAX;
              sat = 1'b1;
            end else begin
              mesh_shadow[addr] = sum[CELL_W-1:0];
            end
          end
          if (sat) r.status = ST_SAT;
        end
      end
      ACT_READ, ACT_WRITE: begin
        if (w.cell_x >= extent[0] || w.cell_y >= extent[1] || w.cell_z >= extent[2]) begin
          r.status = ST_RANGE;
        end else begin
          addr = ({59'd0, w.cell_x} * MESH_Y + w.cell_y) * MESH_Z + w.cell_z;
          if (w.action == ACT_READ) r.cell_value = mesh_shadow[addr];
          else mesh_shadow[addr] = w.write_value;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int a = 0; a < MESH_CELLS; a++) mesh_shadow[a] = '0;
      for (int d = 0; d < DIMENSIONS; d++) begin
        size_reg[d] = RESET_SIZE;
        scale_reg[d] = RESET_SCALE;
      end
      weight_en_reg = 1'b0;
      predicted_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MESH_SIZE_X: size_reg[0] = cfg_wdata[5:0];
          CFG_MESH_SIZE_Y: size_reg[1] = cfg_wdata[5:0];
          CFG_MESH_SIZE_Z: size_reg[2] = cfg_wdata[5:0];
          CFG_SCALE_X:     scale_reg[0] = cfg_wdata;
          CFG_SCALE_Y:     scale_reg[1] = cfg_wdata;
          CFG_SCALE_Z:     scale_reg[2] = cfg_wdata;
          CFG_WEIGHT_EN:   weight_en_reg = cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual status %0d value %h",
                   $time, out_data.status, out_data.cell_value);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_data.status);
            mismatches++;
          end
          if (out_data.cell_value !== want.cell_value) begin
            $display("%0t: cell_value expected %h actual %h",
                     $time, want.cell_value, out_data.cell_value);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted_results.insert(predicted_results.size(), mesh_step(in_data));
      end
    end
    pending = predicted_results.size();
  end

endmodule

// ----- test/tb_cic_mass_assignment_3d_core.sv -----
// ----------------------------------------------------------------------------
// tb_cic_mass_assignment_3d_core
// Drives directed and random deposit, read, write and unused-action words
// into the cloud-in-cell core under several mesh settings, with random
// idling on both channels, and reports the verdict of the attached checker.
// ----------------------------------------------------------------------------
module tb_cic_mass_assignment_3d_core;
  import cicma_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 24;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 250;
  localparam int MESH_MAX        = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [1:0]           ACT_UNUSED = 2'd3;
  localparam logic [31:0]          SCALE_ONE  = 32'h0100_0000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;

  int          mismatches;
  int          pending;
  int          cycles = 0;
  int          stall_left = 0;
  logic        calm = 1'b0;
  logic [5:0]  size_set  [DIMENSIONS];
  logic [31:0] scale_set [DIMENSIONS];
  int          reach     [DIMENSIONS];

  cic_mass_assignment_3d_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  mesh_deposit_checker deposit_check (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .mismatches(mismatches),
    .pending(pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_word_t noise_word();
    in_word_t    w;
    logic [63:0] r;
    r = {$urandom, $urandom};
    w.action = r[1:0];
    w.pos_x = $urandom;
    w.pos_y = $urandom;
    w.pos_z = $urandom;
    w.particle_weight = r[31:8];
    w.cell_x = r[36:32];
    w.cell_y = r[41:37];
    w.cell_z = r[46:42];
    r = {$urandom, $urandom};
    w.write_value = r[CELL_W-1:0];
    return w;
  endfunction

  function automatic in_word_t mk_deposit(input logic [31:0] x, y, z, input logic [23:0] wt);
    in_word_t w;
    w = noise_word();
    w.action = ACT_DEPOSIT;
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    w.particle_weight = wt;
    return w;
  endfunction

  function automatic in_word_t mk_cell(input logic [1:0] act, input logic [4:0] x, y, z,
                                       input logic [CELL_W-1:0] v);
    in_word_t w;
    w = noise_word();
    w.action = act;
    w.cell_x = x;
    w.cell_y = y;
    w.cell_z = z;
    w.write_value = v;
    return w;
  endfunction

  function automatic logic [31:0] aim_axis(input int d);
    logic [63:0] target, p;
    if (scale_set[d] == 0 || $urandom_range(0, 4) == 0) return $urandom;
    target = $urandom_range(0, reach[d] * 65536 - 1);
    p = (target << 24) / {32'd0, scale_set[d]};
    if (p > 64'hFFFF_FFFF) return $urandom;
    return p[31:0];
  endfunction

  function automatic logic [4:0] pick_cell(input int d);
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 31);
    return $urandom_range(0, reach[d] - 1);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w = noise_word();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      w.action = ACT_DEPOSIT;
      w.pos_x = aim_axis(0);
      w.pos_y = aim_axis(1);
      w.pos_z = aim_axis(2);
    end else if (pick < 96) begin
      w.action = (pick < 78) ? ACT_READ : ACT_WRITE;
      w.cell_x = pick_cell(0);
      w.cell_y = pick_cell(1);
      w.cell_z = pick_cell(2);
      if ($urandom_range(0, 3) == 0) w.write_value = CELL_MAX - $urandom_range(0, 1 << 20);
    end else begin
      w.action = ACT_UNUSED;
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic program_mesh(input logic we);
    logic [31:0] r [4];
    for (int i = 0; i < 4; i++) r[i] = $urandom;
    write_reg(CFG_MESH_SIZE_X, {r[0][31:6], size_set[0]});
    write_reg(CFG_MESH_SIZE_Y, {r[1][31:6], size_set[1]});
    write_reg(CFG_MESH_SIZE_Z, {r[2][31:6], size_set[2]});
    write_reg(CFG_SCALE_X, scale_set[0]);
    write_reg(CFG_SCALE_Y, scale_set[1]);
    write_reg(CFG_SCALE_Z, scale_set[2]);
    write_reg(CFG_WEIGHT_EN, {r[3][31:1], we});
    write_reg(CFG_UNUSED, $urandom);
    cfg_wr_en <= 1'b0;
    for (int d = 0; d < DIMENSIONS; d++) begin
      reach[d] = (size_set[d] == 0) ? 1 : (size_set[d] > MESH_MAX) ? MESH_MAX : size_set[d];
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_word_t w;
    for (int d = 0; d < DIMENSIONS; d++) begin
      size_set[d] = 6'd32;
      scale_set[d] = SCALE_ONE;
      reach[d] = MESH_MAX;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_word(mk_deposit(32'h0, 32'h0, 32'h0, 24'hFF_FFFF));
    send_word(mk_cell(ACT_READ, 5'd0, 5'd0, 5'd0, '0));
    send_word(mk_deposit(32'h001F_8000, 32'h001F_8000, 32'h001F_8000, 24'h0));
    send_word(mk_deposit(32'hFFFF_FFFF, 32'h0, 32'h0, 24'h0));
    send_word(mk_deposit(32'h0, 32'h0, 32'h0020_0000, 24'h0));
    send_word(mk_deposit(32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF, 24'h0));
    send_word(mk_cell(ACT_READ, 5'd31, 5'd31, 5'd31, '0));
    send_word(mk_cell(ACT_READ, 5'd0, 5'd0, 5'd31, '0));
    send_word(mk_cell(ACT_WRITE, 5'd5, 5'd5, 5'd5, CELL_MAX - 40'd100));
    send_word(mk_deposit(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 24'h0));
    send_word(mk_cell(ACT_READ, 5'd5, 5'd5, 5'd5, '0));
    send_word(mk_cell(ACT_WRITE, 5'd31, 5'd31, 5'd31, CELL_MAX));
    send_word(mk_cell(ACT_READ, 5'd31, 5'd31, 5'd31, '0));
    w = '1;
    w.action = ACT_UNUSED;
    send_word(w);
    send_word(mk_cell(ACT_WRITE, 5'd0, 5'd0, 5'd0, '0));
    send_word(mk_cell(ACT_READ, 5'd0, 5'd0, 5'd0, '0));
    settle();

    size_set[0] = 6'd0;
    size_set[1] = 6'd63;
    size_set[2] = 6'd1;
    scale_set[0] = 32'h0;
    scale_set[1] = 32'hFFFF_FFFF;
    scale_set[2] = 32'h0080_0000;
    program_mesh(1'b1);
    send_word(mk_deposit(32'hFFFF_FFFF, 32'h0000_0100, 32'h0001_FFFF, 24'hFF_FFFF));
    send_word(mk_deposit(32'h0, 32'h0000_2000, 32'h0, 24'h0));
    send_word(mk_deposit(32'h0, 32'hFFFF_FFFF, 32'h0, 24'h12_3456));
    send_word(mk_cell(ACT_READ, 5'd0, 5'd31, 5'd0, '0));
    send_word(mk_cell(ACT_READ, 5'd1, 5'd0, 5'd0, '0));
    send_word(mk_cell(ACT_WRITE, 5'd0, 5'd0, 5'd1, CELL_MAX));

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      for (int d = 0; d < DIMENSIONS; d++) begin
        if (ph == 0) begin
          size_set[d] = 2 + d;
          scale_set[d] = SCALE_ONE;
        end else begin
          size_set[d] = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 8) : $urandom_range(0, 63);
          case ($urandom_range(0, 6))
            0: scale_set[d] = $urandom;
            1: scale_set[d] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: scale_set[d] = $urandom_range(1 << 22, 1 << 27);
          endcase
        end
      end
      program_mesh(ph == 0 ? 1'b1 : 1'($urandom_range(0, 1)));
      calm <= (ph == PHASES - 1);
      for (int k = 0; k < WORDS_PER_PHASE; k++) send_word(random_word());
    end
    settle();

    if (mismatches == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- cic_mass_assignment_3d_core.f -----
src/cicma_pkg.sv
src/cicma_ram.sv
src/cic_mass_assignment_3d_core.sv
test/mesh_deposit_checker.sv
test/tb_cic_mass_assignment_3d_core.sv
